FILE: rtl/core/watermark_fifo_with_drop_policy_top_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef WATERMARK_FIFO_WITH_DROP_POLICY_TOP_DEFINES_SVH
`define WATERMARK_FIFO_WITH_DROP_POLICY_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define WFD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wfd checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is high.
`define WFD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wfd checker: next-cycle property failed");

`endif

FILE: rtl/core/wfd_pkg.sv
`default_nettype none
package wfd_pkg;

   localparam int MAX_ENTRIES_DEF = 1023;
   localparam int DATA_WIDTH_DEF  = 64;

   localparam int STORE_DEPTH = 1024;
   localparam int PTR_W       = 10;
   localparam int OCC_W       = 10;
   localparam int CNT_W       = 32;
   localparam int WORD_W      = 64;
   localparam int HARD_CAP    = 1023;

   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;

   localparam logic [STATUS_W-1:0] ST_PUSHED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EVICTED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGHWATER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY    = 2'd2;

   localparam logic [OCC_W-1:0] CAP_RESET = 10'd1023;
   localparam logic [OCC_W-1:0] HWL_RESET = 10'd768;

   // Result tdata layout.
   localparam int DOUT_LSB   = 0;
   localparam int DEPTH_LSB  = DOUT_LSB + WORD_W;
   localparam int PEAK_LSB   = DEPTH_LSB + OCC_W;
   localparam int DROP_LSB   = PEAK_LSB + OCC_W;
   localparam int ENQ_LSB    = DROP_LSB + CNT_W;
   localparam int WRT_LSB    = ENQ_LSB + CNT_W;
   localparam int BP_BIT     = WRT_LSB + CNT_W;
   localparam int RSP_USED_W = BP_BIT + 1;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int REQ_DATA_W = WORD_W;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OCC_W-1:0]    depth;
      logic [OCC_W-1:0]    peak;
      logic [CNT_W-1:0]    dropped;
      logic [CNT_W-1:0]    enqueued;
      logic [CNT_W-1:0]    written;
      logic                pressure;
      logic                popped;
   } result_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + CNT_W'(1);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/wfd_ram.sv
`default_nettype none
module wfd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/watermark_fifo_with_drop_policy_top.sv
// An accepted item is registered in stage s1 together with the registered entry RAM read,
// then in the rsp output register, which drives rsp and holds while rsp_tready is low.
// Throughput: one item per cycle while rsp_tready stays high; the registered read of the
// entry RAM sets the two stages.
// Reset clears pointers, depth, statistics and the backpressure flag, and loads the
// registers with capacity 1023, threshold 768 and the reject policy.
// Stored words are not cleared and no clearing pass runs.
`default_nettype none
module watermark_fifo_with_drop_policy_top #(
   parameter int MAX_ENTRIES = wfd_pkg::MAX_ENTRIES_DEF,
   parameter int DATA_WIDTH  = wfd_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [wfd_pkg::REQ_DATA_W-1:0]  req_tdata,  // data_in
   input  wire logic [wfd_pkg::CMD_W-1:0]       req_tuser,  // command
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // data_out, depth, peak_depth, dropped_total, enqueued_total, written_total,
   // backpressure, zero fill
   output logic      [wfd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic      [wfd_pkg::STATUS_W-1:0]    rsp_tuser,  // status
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [wfd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [wfd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import wfd_pkg::*;

   localparam logic [OCC_W-1:0] CAP_CEIL =
      (MAX_ENTRIES < HARD_CAP) ? OCC_W'(MAX_ENTRIES) : OCC_W'(HARD_CAP);

   logic [OCC_W-1:0] cap_ff, hwl_ff;
   logic             dold_ff;

   logic [PTR_W-1:0] rp_ff, rp_in, wp_ff, wp_in;
   logic [OCC_W-1:0] occ_ff, occ_in, peak_ff, peak_in;
   logic [CNT_W-1:0] drop_ff, drop_in, push_ff, push_in, pop_ff, pop_in;
   logic             bp_ff, bp_in;

   logic             s1_valid_ff, s1_valid_in;
   result_type       s1_ff, s1_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]   rsp_user_ff, rsp_user_in;

   logic             accept, out_free;
   logic [OCC_W-1:0] cap_eff, thresh;
   logic             full;
   logic             ram_we, ram_re;
   logic [DATA_WIDTH-1:0] ram_rdata;
   logic [WORD_W-1:0]     pop_word;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CAP_RESET;
         hwl_ff  <= HWL_RESET;
         dold_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CAPACITY:  cap_ff  <= csr_wdata;
            CSR_HIGHWATER: hwl_ff  <= csr_wdata;
            CSR_POLICY:    dold_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cap_eff = (cap_ff > CAP_CEIL) ? CAP_CEIL : cap_ff;
      if (cap_eff == '0) begin
         cap_eff = OCC_W'(1);
      end
      thresh = (hwl_ff == '0) ? OCC_W'(1) : hwl_ff;
   end

   assign full = occ_ff >= cap_eff;

   always_comb begin
      rp_in   = rp_ff;
      wp_in   = wp_ff;
      occ_in  = occ_ff;
      peak_in = peak_ff;
      drop_in = drop_ff;
      push_in = push_ff;
      pop_in  = pop_ff;
      bp_in   = bp_ff;
      ram_we  = 1'b0;
      ram_re  = 1'b0;
      s1_in.status = ST_CLEARED;
      s1_in.popped = 1'b0;
      case (req_tuser)
         CMD_PUSH: begin
            if (full) begin
               drop_in = sat_inc(drop_ff);
            end
            if (full && !dold_ff) begin
               bp_in        = occ_ff >= thresh;
               s1_in.status = ST_REJECTED;
            end else begin
               ram_we  = accept;
               wp_in   = wp_ff + PTR_W'(1);
               push_in = sat_inc(push_ff);
               if (full) begin
                  rp_in        = rp_ff + PTR_W'(1);
                  s1_in.status = ST_EVICTED;
               end else begin
                  occ_in       = occ_ff + OCC_W'(1);
                  s1_in.status = ST_PUSHED;
               end
               if (occ_in > peak_ff) begin
                  peak_in = occ_in;
               end
               bp_in = occ_in >= thresh;
            end
         end
         CMD_POP: begin
            if (occ_ff == '0) begin
               s1_in.status = ST_EMPTY;
            end else begin
               ram_re       = accept;
               rp_in        = rp_ff + PTR_W'(1);
               occ_in       = occ_ff - OCC_W'(1);
               pop_in       = sat_inc(pop_ff);
               s1_in.status = ST_POPPED;
               s1_in.popped = 1'b1;
            end
         end
         default: begin
            peak_in = '0;
            drop_in = '0;
            push_in = '0;
            pop_in  = '0;
         end
      endcase
      s1_in.depth    = occ_in;
      s1_in.peak     = peak_in;
      s1_in.dropped  = drop_in;
      s1_in.enqueued = push_in;
      s1_in.written  = pop_in;
      s1_in.pressure = bp_in;
   end

   wfd_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (req_tdata[DATA_WIDTH-1:0]),
      .rd_en   (ram_re),
      .rd_addr (rp_ff),
      .rd_data (ram_rdata)
   );

   assign pop_word = s1_ff.popped ? WORD_W'(ram_rdata) : '0;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            s1_valid_in = 1'b0;
            rsp_user_in = s1_ff.status;
            rsp_data_in = '0;
            rsp_data_in[DEPTH_LSB-1:DOUT_LSB] = pop_word;
            rsp_data_in[PEAK_LSB-1:DEPTH_LSB] = s1_ff.depth;
            rsp_data_in[DROP_LSB-1:PEAK_LSB]  = s1_ff.peak;
            rsp_data_in[ENQ_LSB-1:DROP_LSB]   = s1_ff.dropped;
            rsp_data_in[WRT_LSB-1:ENQ_LSB]    = s1_ff.enqueued;
            rsp_data_in[BP_BIT-1:WRT_LSB]     = s1_ff.written;
            rsp_data_in[BP_BIT]               = s1_ff.pressure;
         end
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff        <= '0;
         wp_ff        <= '0;
         occ_ff       <= '0;
         peak_ff      <= '0;
         drop_ff      <= '0;
         push_ff      <= '0;
         pop_ff       <= '0;
         bp_ff        <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            rp_ff   <= rp_in;
            wp_ff   <= wp_in;
            occ_ff  <= occ_in;
            peak_ff <= peak_in;
            drop_ff <= drop_in;
            push_ff <= push_in;
            pop_ff  <= pop_in;
            bp_ff   <= bp_in;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

FILE: rtl/core/wfd_checker.sv
`default_nettype none
`include "watermark_fifo_with_drop_policy_top_defines.svh"
module wfd_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [wfd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic [wfd_pkg::STATUS_W-1:0]    rsp_tuser
);
   import wfd_pkg::*;

   logic             is_push;
   logic [WORD_W-1:0] dout;
   logic [OCC_W-1:0]  depth, peak;

   assign is_push = (rsp_tuser == ST_PUSHED) || (rsp_tuser == ST_EVICTED);
   assign dout    = rsp_tdata[DEPTH_LSB-1:DOUT_LSB];
   assign depth   = rsp_tdata[PEAK_LSB-1:DEPTH_LSB];
   assign peak    = rsp_tdata[DROP_LSB-1:PEAK_LSB];

   `WFD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   `WFD_ASSERT_IMP(a_no_data_unless_pop, clock, reset,
      rsp_tvalid && (rsp_tuser != ST_POPPED), dout == '0)

   `WFD_ASSERT_IMP(a_clear_zeroes_stats, clock, reset,
      rsp_tvalid && (rsp_tuser == ST_CLEARED),
      (peak == '0) && (rsp_tdata[BP_BIT-1:DROP_LSB] == '0))

   `WFD_ASSERT_IMP(a_push_raises_peak, clock, reset, rsp_tvalid && is_push,
      (depth != '0) && (peak >= depth) && (rsp_tdata[WRT_LSB-1:ENQ_LSB] != '0))

endmodule

bind watermark_fifo_with_drop_policy_top wfd_checker u_wfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
